// File: src/cbaf_pkg.sv
// Shared types and constants for the cubic Bezier adaptive flattening core.
// Used by cubic_bezier_adaptive_flatten_core; no dependencies.
package cbaf_pkg;

    localparam int MAX_DEPTH  = 6;
    localparam int COORD_W    = 32;
    localparam int WIDTH_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_W     = DIFF_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS + 1);
    localparam int LVL_W      = $clog2(MAX_DEPTH + 1);
    localparam int TOP_W      = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int POLY_W     = ROOT_W + 2;

    localparam int MIN_W      = 31;
    localparam int TOL_W      = 18;
    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_KNOT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 2'd2;

    localparam logic [MIN_W-1:0]   MIN_RESET  = 31'd6554;
    localparam logic [TOL_W-1:0]   TOL_RESET  = 18'd65864;
    localparam logic [WIDTH_W-1:0] MAXW_RESET = 24'd3277;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [WIDTH_W-1:0]        w;
    } point_t;

    typedef point_t [3:0] piece_t;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        piece_t           piece;
    } stack_entry_t;

    localparam int ENTRY_W = $bits(stack_entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_ADD,
        ST_ROOT,
        ST_TOL,
        ST_DEC,
        ST_EMIT,
        ST_POP
    } state_t;

    function automatic logic signed [COORD_W-1:0] mid_coord(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [DIFF_W-1:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[DIFF_W-1:1];
    endfunction

    function automatic logic [WIDTH_W-1:0] mid_width(
        input logic [WIDTH_W-1:0] a,
        input logic [WIDTH_W-1:0] b
    );
        logic [WIDTH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WIDTH_W:1];
    endfunction

endpackage

// File: src/cbaf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cbaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/cubic_bezier_adaptive_flatten_core.sv
// Top level of the cubic Bezier adaptive flattening core.
// Depends on cbaf_pkg and cbaf_ram (stack of pending right halves).
//
// One segment is taken per beat on the input channel while the core is idle; it
// is split at its midpoint depth first, left half first, and one output beat is
// given per flat or depth-limited piece carrying the piece's start knot, last_point
// marking the final one. Every visited piece costs a flatness test of four
// distances run through one shared 33x33 multiplier and a one-bit-per-cycle square
// root, the split taking place in its last step. The emit step waits while the
// output is stalled, and each pending half is read back from the stack before
// its test. A segment visits from one piece (flat at once) up to 127 pieces at a
// depth of 6. The pending halves live in a 6-entry RAM; no clearing pass is needed
// after reset.
module cubic_bezier_adaptive_flatten_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cbaf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbaf_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [cbaf_pkg::COORD_W-1:0] start_x,
    input  logic signed [cbaf_pkg::COORD_W-1:0] start_y,
    input  logic [cbaf_pkg::WIDTH_W-1:0]        start_w,
    input  logic signed [cbaf_pkg::COORD_W-1:0] ctrl_a_x,
    input  logic signed [cbaf_pkg::COORD_W-1:0] ctrl_a_y,
    input  logic [cbaf_pkg::WIDTH_W-1:0]        ctrl_a_w,
    input  logic signed [cbaf_pkg::COORD_W-1:0] ctrl_b_x,
    input  logic signed [cbaf_pkg::COORD_W-1:0] ctrl_b_y,
    input  logic [cbaf_pkg::WIDTH_W-1:0]        ctrl_b_w,
    input  logic signed [cbaf_pkg::COORD_W-1:0] end_x,
    input  logic signed [cbaf_pkg::COORD_W-1:0] end_y,
    input  logic [cbaf_pkg::WIDTH_W-1:0]        end_w,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [cbaf_pkg::COORD_W-1:0] point_x,
    output logic signed [cbaf_pkg::COORD_W-1:0] point_y,
    output logic [cbaf_pkg::WIDTH_W-1:0]        point_w,
    output logic                                last_point,
    output logic                                depth_limited
);

    import cbaf_pkg::*;

    state_t state_reg, state_next;

    logic [MIN_W-1:0]   min_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [WIDTH_W-1:0] maxw_reg;

    piece_t            piece_reg;
    logic [LVL_W-1:0]  level_reg;
    logic [TOP_W-1:0]  top_reg;
    logic [1:0]        pair_reg;
    logic [STEP_W-1:0] step_reg;

    logic [DIFF_W-1:0] ax_reg, ay_reg;
    logic [SQ_W-1:0]   prod_reg, sum_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] len_reg [4];
    logic [POLY_W-1:0] poly_reg;
    logic              flat_reg;

    logic                     out_valid_reg, last_reg, limited_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic [WIDTH_W-1:0]       pw_reg;

    logic [DIFF_W-1:0] mul_a, mul_b;
    logic [SQ_W-1:0]   mul_p;
    logic              out_free;
    logic              emit_now;
    logic              ram_we;
    stack_entry_t      ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_bits;

    point_t            pp, pq;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [REM_W-1:0]  rem_shift, trial;
    logic              flat_now;
    logic [WIDTH_W-1:0] wc;
    piece_t            left, right;
    point_t            b0, b1, b2, c0, c1, m;

    assign out_free = !out_valid_reg || !out_stall;

    // pair selection for distance
    always_comb
    begin
        case (pair_reg)
            2'd0:
            begin
                pp = piece_reg[0];
                pq = piece_reg[1];
            end
            2'd1:
            begin
                pp = piece_reg[1];
                pq = piece_reg[2];
            end
            2'd2:
            begin
                pp = piece_reg[2];
                pq = piece_reg[3];
            end
            default:
            begin
                pp = piece_reg[0];
                pq = piece_reg[3];
            end
        endcase
        dx = {pq.x[COORD_W-1], pq.x} - {pp.x[COORD_W-1], pp.x};
        dy = {pq.y[COORD_W-1], pq.y} - {pp.y[COORD_W-1], pp.y};
    end

    assign mul_p     = {{DIFF_W{1'b0}}, mul_a} * {{DIFF_W{1'b0}}, mul_b};
    assign rem_shift = {rem_reg[REM_W-3:0], sum_reg[SQ_W-1:SQ_W-2]};
    assign trial     = {1'b0, root_reg, 2'b01};

    assign wc = (piece_reg[0].w >= piece_reg[3].w) ? piece_reg[0].w - piece_reg[3].w
                                                   : piece_reg[3].w - piece_reg[0].w;
    assign flat_now = (len_reg[3] < {{(ROOT_W - MIN_W){1'b0}}, min_reg})
        || (({{(SQ_W - POLY_W - 16){1'b0}}, poly_reg, 16'd0} < prod_reg)
            && (wc < maxw_reg));
    assign emit_now = flat_now || (level_reg >= LVL_W'(MAX_DEPTH))
        || (top_reg >= TOP_W'(MAX_DEPTH));

    // de Casteljau split at t = 1/2
    always_comb
    begin
        b0.x = mid_coord(piece_reg[0].x, piece_reg[1].x);
        b1.x = mid_coord(piece_reg[1].x, piece_reg[2].x);
        b2.x = mid_coord(piece_reg[2].x, piece_reg[3].x);
        b0.y = mid_coord(piece_reg[0].y, piece_reg[1].y);
        b1.y = mid_coord(piece_reg[1].y, piece_reg[2].y);
        b2.y = mid_coord(piece_reg[2].y, piece_reg[3].y);
        b0.w = mid_width(piece_reg[0].w, piece_reg[1].w);
        b1.w = mid_width(piece_reg[1].w, piece_reg[2].w);
        b2.w = mid_width(piece_reg[2].w, piece_reg[3].w);
        c0.x = mid_coord(b0.x, b1.x);
        c1.x = mid_coord(b1.x, b2.x);
        c0.y = mid_coord(b0.y, b1.y);
        c1.y = mid_coord(b1.y, b2.y);
        c0.w = mid_width(b0.w, b1.w);
        c1.w = mid_width(b1.w, b2.w);
        m.x  = mid_coord(c0.x, c1.x);
        m.y  = mid_coord(c0.y, c1.y);
        m.w  = mid_width(c0.w, c1.w);
        left[0]  = piece_reg[0];
        left[1]  = b0;
        left[2]  = c0;
        left[3]  = m;
        right[0] = m;
        right[1] = c1;
        right[2] = b2;
        right[3] = piece_reg[3];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = (pair_reg == 2'd3) ? ST_TOL : ST_DIFF;
                end
            end
            ST_TOL: state_next = ST_DEC;
            ST_DEC: state_next = emit_now ? ST_EMIT : ST_DIFF;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (top_reg == '0) ? ST_IDLE : ST_POP;
                end
            end
            ST_POP:  state_next = ST_DIFF;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        ram_we   = (state_reg == ST_DEC) && !emit_now;
        mul_a    = ax_reg;
        mul_b    = ax_reg;
        case (state_reg)
            ST_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            ST_TOL:
            begin
                mul_a = {{(DIFF_W - TOL_W){1'b0}}, tol_reg};
                mul_b = len_reg[3];
            end
            default:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
        endcase
    end

    assign ram_wdata.level = level_reg + LVL_W'(1);
    assign ram_wdata.piece = right;
    assign ram_rdata       = stack_entry_t'(ram_rdata_bits);

    cbaf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (top_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (ADDR_W'(top_reg - TOP_W'(1))),
        .rdata (ram_rdata_bits)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= MIN_RESET;
            tol_reg       <= TOL_RESET;
            maxw_reg      <= MAXW_RESET;
            out_valid_reg <= 1'b0;
            top_reg       <= '0;
            level_reg     <= '0;
            pair_reg      <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_KNOT:  min_reg  <= cfg_data[MIN_W-1:0];
                    CFG_TOLERANCE: tol_reg  <= cfg_data[TOL_W-1:0];
                    CFG_MAX_WIDTH: maxw_reg <= cfg_data[WIDTH_W-1:0];
                    default:       ;
                endcase
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        top_reg   <= '0;
                        level_reg <= '0;
                        pair_reg  <= '0;
                    end
                end
                ST_ADD: step_reg <= '0;
                ST_ROOT:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    begin
                        pair_reg <= pair_reg + 2'd1;
                    end
                end
                ST_DEC:
                begin
                    if (!emit_now)
                    begin
                        top_reg   <= top_reg + TOP_W'(1);
                        level_reg <= level_reg + LVL_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (out_free && (top_reg != '0))
                    begin
                        top_reg <= top_reg - TOP_W'(1);
                    end
                end
                ST_POP: level_reg <= ram_rdata.level;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    piece_reg[0] <= '{x: start_x, y: start_y, w: start_w};
                    piece_reg[1] <= '{x: ctrl_a_x, y: ctrl_a_y, w: ctrl_a_w};
                    piece_reg[2] <= '{x: ctrl_b_x, y: ctrl_b_y, w: ctrl_b_w};
                    piece_reg[3] <= '{x: end_x, y: end_y, w: end_w};
                end
            end
            ST_DIFF:
            begin
                ax_reg <= dx[DIFF_W-1] ? DIFF_W'(~dx + DIFF_W'(1)) : dx;
                ay_reg <= dy[DIFF_W-1] ? DIFF_W'(~dy + DIFF_W'(1)) : dy;
            end
            ST_SQX: prod_reg <= mul_p;
            ST_SQY:
            begin
                sum_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            ST_ADD:
            begin
                sum_reg  <= sum_reg + prod_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            ST_ROOT:
            begin
                sum_reg <= {sum_reg[SQ_W-3:0], 2'b00};
                if (rem_shift >= trial)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    begin
                        len_reg[pair_reg] <= {root_reg[ROOT_W-2:0], 1'b1};
                    end
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    if (step_reg == STEP_W'(ROOT_STEPS - 1))
                    begin
                        len_reg[pair_reg] <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                end
            end
            ST_TOL:
            begin
                prod_reg <= mul_p;
                poly_reg <= POLY_W'(len_reg[0]) + POLY_W'(len_reg[1]) + POLY_W'(len_reg[2]);
            end
            ST_DEC:
            begin
                flat_reg <= flat_now;
                if (!emit_now)
                begin
                    piece_reg <= left;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    px_reg      <= piece_reg[0].x;
                    py_reg      <= piece_reg[0].y;
                    pw_reg      <= piece_reg[0].w;
                    last_reg    <= (top_reg == '0);
                    limited_reg <= !flat_reg;
                end
            end
            ST_POP: piece_reg <= ram_rdata.piece;
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign point_x       = px_reg;
    assign point_y       = py_reg;
    assign point_w       = pw_reg;
    assign last_point    = last_reg;
    assign depth_limited = limited_reg;

endmodule
